// ===== hdl/pom_pkg.sv =====
`default_nettype none

package pom_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF  = 16;

   localparam int NUM_W   = 20;
   localparam int DC_W    = 16;
   localparam int SPO2_W  = 7;
   localparam int PULSE_W = 23;
   localparam int OUT_W   = ((SPO2_W + PULSE_W + 7) / 8) * 8;

   localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(30000);

   // quotient bits produced by the shared divider for each job
   localparam int PULSE_QBITS = 24;
   localparam int SPO2_QBITS  = 7;
   localparam int ITER_W      = 5;

   localparam logic [1:0] CROSS_START = 2'd1;
   localparam logic [1:0] CROSS_EMIT  = 2'd3;

   localparam logic [SPO2_W-1:0] SPO2_FULL = SPO2_W'(100);
   localparam int SPO2_K_LOW  = 110;
   localparam int SPO2_M_LOW  = 25;
   localparam int SPO2_K_HIGH = 120;
   localparam int SPO2_M_HIGH = 35;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_PP        = 9'b000000010,
      S_MUL_N     = 9'b000000100,
      S_MUL_D     = 9'b000001000,
      S_CLASSIFY  = 9'b000010000,
      S_DIV_PULSE = 9'b000100000,
      S_SPO2_LOAD = 9'b001000000,
      S_DIV_SPO2  = 9'b010000000,
      S_DONE      = 9'b100000000
   } state_type;

   typedef struct packed {
      logic fold;
      logic pp;
      logic mul_n;
      logic mul_d;
      logic classify;
      logic div_load_pulse;
      logic div_load_spo2;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit_due;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/pom_divider.sv =====
`default_nettype none

module pom_divider #(
   parameter int DIV_W = 40,
   parameter int Q_W   = 24,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             step,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   input  logic [CNT_W-1:0] iters,
   output logic [Q_W-1:0]   quotient,
   output logic             last
);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fits;

   // restoring division, one quotient bit a cycle while step is high, divisor pre-shifted to the top bit
   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = divisor;
         q_in   = '0;
         cnt_in = iters;
      end else if (step) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign last     = (cnt_ff == CNT_W'(1));

endmodule

`default_nettype wire

// ===== hdl/pom_ctrl.sv =====
`default_nettype none

module pom_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pom_pkg::status_type sts,
   output pom_pkg::cmd_type    cmd
);

   import pom_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.fold = 1'b1;
               if (sts.emit_due) begin
                  state_in = S_PP;
               end
            end
         end
         S_PP: begin
            cmd.pp   = 1'b1;
            state_in = S_MUL_N;
         end
         S_MUL_N: begin
            cmd.mul_n = 1'b1;
            state_in  = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.mul_d = 1'b1;
            state_in  = S_CLASSIFY;
         end
         S_CLASSIFY: begin
            cmd.classify       = 1'b1;
            cmd.div_load_pulse = 1'b1;
            state_in           = S_DIV_PULSE;
         end
         S_DIV_PULSE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_SPO2_LOAD;
            end
         end
         S_SPO2_LOAD: begin
            cmd.div_load_spo2 = 1'b1;
            state_in          = S_DIV_SPO2;
         end
         S_DIV_SPO2: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold the finished result until the output register is free
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pom_datapath.sv =====
`default_nettype none

module pom_datapath #(
   parameter int SAMPLE_WIDTH = pom_pkg::SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = pom_pkg::COUNT_WIDTH_DEF,
   parameter int IN_W         = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pom_pkg::cmd_type           cmd,
   output pom_pkg::status_type        sts,
   input  logic [IN_W-1:0]            req_tdata,
   input  logic                       csr_wr_en,
   input  logic [pom_pkg::NUM_W-1:0]  csr_wr_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [pom_pkg::OUT_W-1:0]  rsp_tdata,
   output logic                       rsp_tuser
);

   import pom_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int PP_W   = SW + 1;
   localparam int PROD_W = PP_W + DC_W;
   localparam int DIV_W  = (SW + 24 > COUNT_WIDTH + PULSE_QBITS - 1) ?
                           SW + 24 : COUNT_WIDTH + PULSE_QBITS - 1;

   // input fields
   logic signed [SW-1:0] acr, acir;
   logic [DC_W-1:0]      dcr, dcir;

   assign acr  = req_tdata[SW-1:0];
   assign acir = req_tdata[2*SW-1:SW];
   assign dcr  = req_tdata[2*SW+DC_W-1:2*SW];
   assign dcir = req_tdata[2*SW+2*DC_W-1:2*SW+DC_W];

   logic [NUM_W-1:0]       num_ff;
   logic signed [SW-1:0]   prev_ff;
   logic [1:0]             cross_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic signed [SW-1:0]   rmax_ff, rmin_ff, imax_ff, imin_ff;
   logic [DC_W-1:0]        dcr_ff, dcir_ff;
   logic [PP_W-1:0]        ppr_ff, ppir_ff;
   logic [PROD_W-1:0]      n_ff, d_ff;
   logic                   lt04_ff, le1_ff, le34_ff, err_ff;
   logic [PULSE_W-1:0]     pulse_ff;
   logic                   rsp_tvalid_ff;
   logic [SPO2_W-1:0]      rsp_spo2_ff;
   logic [PULSE_W-1:0]     rsp_pulse_ff;
   logic                   rsp_err_ff;

   logic signed [SW-1:0] rmax_in, rmin_in, imax_in, imin_in;
   logic                 acr_pos, acr_neg, prev_pos, prev_neg, crossing;
   logic                 count_full;

   always_comb begin
      rmax_in = (acr > rmax_ff) ? acr : rmax_ff;
      rmin_in = (acr < rmin_ff) ? acr : rmin_ff;
      imax_in = (acir > imax_ff) ? acir : imax_ff;
      imin_in = (acir < imin_ff) ? acir : imin_ff;
   end

   assign acr_neg    = acr[SW-1];
   assign acr_pos    = !acr[SW-1] && (|acr);
   assign prev_neg   = prev_ff[SW-1];
   assign prev_pos   = !prev_ff[SW-1] && (|prev_ff);
   assign crossing   = (acr_pos && prev_neg) || (acr_neg && prev_pos);
   assign count_full = &count_ff;

   // shared multiplier for both cross products
   logic [PROD_W-1:0] prod;
   assign prod = cmd.mul_n ? PROD_W'(ppr_ff) * PROD_W'(dcir_ff)
                           : PROD_W'(ppir_ff) * PROD_W'(dcr_ff);

   // ratio classification against 0.4, 1 and 3.4
   logic [PROD_W+2:0] n5, d2;
   logic [PROD_W+4:0] d17;
   assign n5  = {n_ff, 2'b00} + (PROD_W+3)'(n_ff);
   assign d2  = (PROD_W+3)'({d_ff, 1'b0});
   assign d17 = {d_ff, 4'b0000} + (PROD_W+5)'(d_ff);

   // divider operands
   logic [DIV_W-1:0] n_x, d_x, spo2_num, div_dividend, div_divisor;
   logic [ITER_W-1:0] div_iters;
   logic [PULSE_QBITS-1:0] quotient;
   logic div_last;

   assign n_x      = DIV_W'(n_ff);
   assign d_x      = DIV_W'(d_ff);
   assign spo2_num = le1_ff ? DIV_W'(SPO2_K_LOW) * d_x - DIV_W'(SPO2_M_LOW) * n_x
                            : DIV_W'(SPO2_K_HIGH) * d_x - DIV_W'(SPO2_M_HIGH) * n_x;

   always_comb begin
      if (cmd.div_load_pulse) begin
         div_dividend = DIV_W'({num_ff, 4'b0000});
         div_divisor  = DIV_W'(count_ff) << (PULSE_QBITS - 1);
         div_iters    = ITER_W'(PULSE_QBITS);
      end else begin
         div_dividend = spo2_num;
         div_divisor  = d_x << (SPO2_QBITS - 1);
         div_iters    = ITER_W'(SPO2_QBITS);
      end
   end

   pom_divider #(
      .DIV_W (DIV_W),
      .Q_W   (PULSE_QBITS),
      .CNT_W (ITER_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.div_load_pulse || cmd.div_load_spo2),
      .step     (cmd.div_step),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .quotient (quotient),
      .last     (div_last)
   );

   logic [SPO2_W-1:0] spo2_val;
   always_comb begin
      if (err_ff) begin
         spo2_val = '0;
      end else if (lt04_ff) begin
         spo2_val = SPO2_FULL;
      end else if (le1_ff || le34_ff) begin
         spo2_val = quotient[SPO2_W-1:0];
      end else begin
         spo2_val = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= NUM_RESET;
         prev_ff  <= '0;
         cross_ff <= CROSS_START;
         count_ff <= '0;
         rmax_ff  <= '0;
         rmin_ff  <= '0;
         imax_ff  <= '0;
         imin_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            num_ff <= csr_wr_data;
         end
         if (cmd.fold) begin
            prev_ff <= acr;
            rmax_ff <= rmax_in;
            rmin_ff <= rmin_in;
            imax_ff <= imax_in;
            imin_ff <= imin_in;
            if (cross_ff != CROSS_EMIT) begin
               if (crossing) begin
                  cross_ff <= cross_ff + 2'd1;
               end
               if (!count_full) begin
                  count_ff <= count_ff + COUNT_WIDTH'(1);
               end
            end
         end
         if (cmd.pp) begin
            cross_ff <= CROSS_START;
            rmax_ff  <= '0;
            rmin_ff  <= '0;
            imax_ff  <= '0;
            imin_ff  <= '0;
         end
         if (cmd.out_load) begin
            count_ff <= '0;
         end
      end
   end

   // computation registers
   always_ff @(posedge clock) begin
      if (cmd.fold) begin
         dcr_ff  <= dcr;
         dcir_ff <= dcir;
      end
      if (cmd.pp) begin
         ppr_ff  <= {rmax_ff[SW-1], rmax_ff} - {rmin_ff[SW-1], rmin_ff};
         ppir_ff <= {imax_ff[SW-1], imax_ff} - {imin_ff[SW-1], imin_ff};
      end
      if (cmd.mul_n) begin
         n_ff <= prod;
      end
      if (cmd.mul_d) begin
         d_ff <= prod;
      end
      if (cmd.classify) begin
         lt04_ff <= (n5 < d2);
         le1_ff  <= (n_ff <= d_ff);
         le34_ff <= ((PROD_W+5)'(n5) <= d17);
         err_ff  <= (dcr_ff == '0) || (dcir_ff == '0) || (ppir_ff == '0);
      end
      if (cmd.div_load_spo2) begin
         pulse_ff <= (count_ff == '0) ? '0 : quotient[PULSE_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_spo2_ff  <= spo2_val;
         rsp_pulse_ff <= pulse_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OUT_W'({rsp_pulse_ff, rsp_spo2_ff});
   assign rsp_tuser  = rsp_err_ff;

   assign sts.emit_due = (cross_ff == CROSS_EMIT);
   assign sts.div_last = div_last;
   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

endmodule

`default_nettype wire

// ===== hdl/pulse_oximeter_measure.sv =====
// Pulse oximeter measurement: SpO2 by ratio of ratios, and pulse rate.
// req channel: one transfer per sample of red/infrared AC and DC levels.
// rsp channel: one transfer after every second red zero crossing, holding
//    SpO2 percent and pulse in beats per minute with four fractional bits;
//    tuser flags a zero dc level or a zero infrared swing (SpO2 is then 0).
// csr_wr_en/csr_wr_data write the pulse numerator (60 / sample period);
//    write it only while no sample is in flight.
// A sample that produces no result does not stall intake: req_tready stays high.
// A sample that produces a result drops req_tready while the block forms the swings,
//    the two cross products and the ratio class, then runs the one shared restoring
//    divider that yields one quotient bit a cycle, first for pulse then for SpO2.
// The result sits in an output register; the next sample is taken while it
//    waits. If the receiver still stalls when the following result is ready,
//    the block holds that result and drops req_tready until rsp frees up.
// Reset (synchronous) loads numerator 30000, clears the sample count and extremes,
//    sets the crossing count to its start value and empties the output register.
`default_nettype none

module pulse_oximeter_measure #(
   parameter int SAMPLE_WIDTH = pom_pkg::SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = pom_pkg::COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // ac_red, ac_infrared, dc_red, dc_infrared
   input  logic [((2*SAMPLE_WIDTH+2*pom_pkg::DC_W+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // spo2_percent, pulse_q4
   output logic [pom_pkg::OUT_W-1:0] rsp_tdata,
   // ratio_error
   output logic                      rsp_tuser,
   input  logic                      csr_wr_en,
   input  logic [pom_pkg::NUM_W-1:0] csr_wr_data
);

   import pom_pkg::*;

   localparam int IN_W = ((2*SAMPLE_WIDTH + 2*DC_W + 7) / 8) * 8;

   cmd_type    cmd;
   status_type sts;

   pom_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pom_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .IN_W         (IN_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // a result is never loaded over one the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending transfer");

   // a sample that completes a cycle stops intake while the result is computed
   a_busy_after_emit: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && sts.emit_due) |=> !req_tready)
      else $error("input taken while a result is being computed");

   // a denominator error forces SpO2 to zero
   a_err_spo2_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[SPO2_W-1:0] == '0))
      else $error("error flagged with nonzero spo2");

   a_spo2_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[SPO2_W-1:0] <= SPO2_FULL))
      else $error("spo2 above full saturation");

endmodule

`default_nettype wire

// ===== dv/pulse_oximeter_measure_tb.sv =====
`timescale 1ns / 100ps

module pulse_oximeter_measure_tb;

   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 163;
   localparam int FILL_ITEMS    = 40;

   // ac_red lowest, dc_infrared highest
   typedef struct packed {
      logic [pom_pkg::DC_W-1:0] dc_ir;
      logic [pom_pkg::DC_W-1:0] dc_red;
      logic [15:0]              ac_ir;
      logic [15:0]              ac_red;
   } sample_type;

   typedef struct packed {
      logic [pom_pkg::SPO2_W-1:0]  spo2;
      logic [pom_pkg::PULSE_W-1:0] pulse;
      logic                        err;
   } oximetry_type;

   typedef struct {
      sample_type   smp;
      bit           typed;
      oximetry_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [63:0]                 req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b1;
   logic [pom_pkg::OUT_W-1:0]   rsp_tdata;
   logic                        rsp_tuser;
   logic                        csr_wr_en   = 1'b0;
   logic [pom_pkg::NUM_W-1:0]   csr_wr_data = '0;

   // predictor state
   logic [pom_pkg::NUM_W-1:0]             numer_q = pom_pkg::NUM_RESET;
   logic signed [15:0]                    last_red = '0;
   logic [1:0]                            cross_cnt = pom_pkg::CROSS_START;
   logic [pom_pkg::COUNT_WIDTH_DEF-1:0]   sample_cnt = '0;
   logic signed [15:0]                    red_hi = '0, red_lo = '0, ir_hi = '0, ir_lo = '0;

   oximetry_type oximetry_due[$];
   stim_row_type stim_table[$];
   int           mismatch_count = 0;
   int           idle_pct = 0;
   int           rsp_stall = 0;

   // waveform generator state
   bit seg_neg = 1'b0;
   int seg_left = 0;
   bit wave_matched = 1'b0;

   pulse_oximeter_measure DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [pom_pkg::SPO2_W-1:0] spo2_of(input longint unsigned n,
                                                          input longint unsigned d);
      // ratio n/d compared against 0.4, 1 and 3.4 without division
      if (5 * n < 2 * d)
         return pom_pkg::SPO2_FULL;
      if (n <= d)
         return pom_pkg::SPO2_W'((pom_pkg::SPO2_K_LOW * d - pom_pkg::SPO2_M_LOW * n) / d);
      if (5 * n <= 17 * d)
         return pom_pkg::SPO2_W'((pom_pkg::SPO2_K_HIGH * d - pom_pkg::SPO2_M_HIGH * n) / d);
      return '0;
   endfunction

   function automatic bit predict_oximetry(input sample_type s, output oximetry_type r);
      logic signed [15:0] red;
      logic signed [15:0] ir;
      longint unsigned    ppr;
      longint unsigned    ppir;
      longint unsigned    num;
      longint unsigned    den;
      bit                 emit;
      red  = s.ac_red;
      ir   = s.ac_ir;
      emit = 1'b0;
      r    = '0;
      if (red > red_hi) red_hi = red;
      if (red < red_lo) red_lo = red;
      if (ir > ir_hi) ir_hi = ir;
      if (ir < ir_lo) ir_lo = ir;
      if (cross_cnt != pom_pkg::CROSS_EMIT) begin
         if ((red > 0 && last_red < 0) || (red < 0 && last_red > 0))
            cross_cnt = cross_cnt + 2'd1;
         if (sample_cnt != '1)
            sample_cnt = sample_cnt + 1'b1;
      end else begin
         ppr  = int'(red_hi) - int'(red_lo);
         ppir = int'(ir_hi) - int'(ir_lo);
         num  = ppr * s.dc_ir;
         den  = ppir * s.dc_red;
         if (s.dc_red == 0 || s.dc_ir == 0 || ppir == 0)
            r.err = 1'b1;
         else
            r.spo2 = spo2_of(num, den);
         if (sample_cnt != 0)
            r.pulse = pom_pkg::PULSE_W'((longint'(numer_q) * 16) / sample_cnt);
         emit       = 1'b1;
         cross_cnt  = pom_pkg::CROSS_START;
         sample_cnt = '0;
         red_hi = '0;
         red_lo = '0;
         ir_hi  = '0;
         ir_lo  = '0;
      end
      last_red = red;
      return emit;
   endfunction

   task automatic add_row(input int red, input int ir, input int dcr, input int dcir,
                          input bit typed, input int spo2, input int pulse, input bit err);
      stim_row_type row;
      row.smp.ac_red     = 16'(red);
      row.smp.ac_ir      = 16'(ir);
      row.smp.dc_red     = 16'(dcr);
      row.smp.dc_ir      = 16'(dcir);
      row.typed          = typed;
      row.want.spo2      = pom_pkg::SPO2_W'(spo2);
      row.want.pulse     = pom_pkg::PULSE_W'(pulse);
      row.want.err       = err;
      stim_table.push_back(row);
   endtask

   task automatic send_sample(input sample_type s, input bit typed, input oximetry_type want);
      oximetry_type got;
      bit           emits;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      emits = predict_oximetry(s, got);
      if (emits)
         oximetry_due.push_back(typed ? want : got);
   endtask

   // let outstanding results drain, then give the divider time to go idle
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (oximetry_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_numerator(input logic [pom_pkg::NUM_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      numer_q = value;
   endtask

   function automatic logic [15:0] rand_ac(input bit neg);
      int m;
      case ($urandom_range(0, 7))
         0:       m = neg ? 32768 : 32767;
         1, 2:    m = $urandom_range(0, 15);
         default: m = $urandom_range(1, 32767);
      endcase
      return neg ? 16'(-m) : 16'(m);
   endfunction

   function automatic logic [15:0] rand_dc();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 16'($urandom_range(1, 15));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   // alternating red half-waves so crossings come regularly, plus some noise
   function automatic sample_type make_wave_sample();
      sample_type s;
      int         k;
      int         off;
      if ($urandom_range(0, 9) == 0) begin
         s = {$urandom(), $urandom()};
         return s;
      end
      if (seg_left == 0) begin
         seg_neg  = !seg_neg;
         seg_left = $urandom_range(1, 5);
      end
      seg_left--;
      s.ac_red = rand_ac(seg_neg);
      s.ac_ir  = wave_matched ? s.ac_red : rand_ac($urandom_range(0, 1));
      s.dc_red = rand_dc();
      s.dc_ir  = rand_dc();
      if (cross_cnt == pom_pkg::CROSS_EMIT) begin
         if (wave_matched) begin
            // equal peak-to-peak, so the ratio is dc_ir/dc_red: land on or next to a breakpoint
            k   = $urandom_range(1, 3854);
            off = $urandom_range(0, 2) - 1;
            case ($urandom_range(0, 2))
               0: begin s.dc_red = 16'(5 * k); s.dc_ir = 16'(2 * k + off);  end
               1: begin s.dc_red = 16'(k);     s.dc_ir = 16'(k + off);      end
               default: begin s.dc_red = 16'(5 * k); s.dc_ir = 16'(17 * k + off); end
            endcase
         end
         wave_matched = ($urandom_range(0, 2) == 0);
      end
      return s;
   endfunction

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct / 2) begin
         rsp_stall  <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      oximetry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (oximetry_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result spo2 %0d pulse %0d err %0b", $realtime,
                        rsp_tdata[pom_pkg::SPO2_W-1:0],
                        rsp_tdata[pom_pkg::SPO2_W +: pom_pkg::PULSE_W], rsp_tuser);
         end else begin
            want = oximetry_due.pop_front();
            if (rsp_tdata[pom_pkg::SPO2_W-1:0] !== want.spo2 ||
                rsp_tdata[pom_pkg::SPO2_W +: pom_pkg::PULSE_W] !== want.pulse ||
                rsp_tuser !== want.err) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: spo2 exp %0d got %0d, pulse exp %0d got %0d, err exp %0b got %0b",
                           $realtime, want.spo2, rsp_tdata[pom_pkg::SPO2_W-1:0],
                           want.pulse, rsp_tdata[pom_pkg::SPO2_W +: pom_pkg::PULSE_W],
                           want.err, rsp_tuser);
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("pulse_oximeter_measure_tb: FAIL");
      $finish;
   end

   initial begin
      sample_type s;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // numerator at its reset value for the whole table
      add_row(   100,     50,  1000,  1000, 0,   0,      0, 0);
      add_row(  -100,    -50,  1000,  1000, 0,   0,      0, 0);
      add_row(   100,     50,  1000,  1000, 0,   0,      0, 0);
      // zero red dc
      add_row(   100,     50,     0,  1000, 1,   0, 160000, 1);
      // full-scale swings on both channels, ratio exactly one
      add_row(-32768,  32767, 65535, 65535, 0,   0,      0, 0);
      add_row( 32767, -32768, 65535, 65535, 0,   0,      0, 0);
      add_row(     0,      0, 65535, 65535, 1,  85, 240000, 0);
      // zeros never count as a crossing; flat infrared swing
      add_row(     0,      0,  1000,  1000, 0,   0,      0, 0);
      add_row(     1,      0,  1000,  1000, 0,   0,      0, 0);
      add_row(    -1,      0,  1000,  1000, 0,   0,      0, 0);
      add_row(     0,      0,  1000,  1000, 0,   0,      0, 0);
      add_row(     5,      0,  1000,  1000, 0,   0,      0, 0);
      add_row(    -5,      0,  1000,  1000, 0,   0,      0, 0);
      add_row(     3,      0,  1000,  1000, 1,   0,  80000, 1);
      // zero infrared dc
      add_row(    -3,     10,  1000,  1000, 0,   0,      0, 0);
      add_row(     3,    -10,  1000,  1000, 0,   0,      0, 0);
      add_row(     0,      0,   100,     0, 1,   0, 240000, 1);
      // ratio far below 0.4
      add_row(     1,   1000,  1000,  1000, 0,   0,      0, 0);
      add_row(    -1,  -1000,  1000,  1000, 0,   0,      0, 0);
      add_row(     1,   1000,  1000,  1000, 0,   0,      0, 0);
      add_row(     0,      0,  1000,  1000, 1, 100, 160000, 0);
      // ratio far above 3.4
      add_row(  1000,      1,  1000,  1000, 0,   0,      0, 0);
      add_row( -1000,     -1,  1000,  1000, 0,   0,      0, 0);
      add_row(  1000,      1,  1000,  1000, 0,   0,      0, 0);
      add_row(     0,      0,  1000,  1000, 1,   0, 160000, 0);

      idle_pct = 20;
      foreach (stim_table[i])
         send_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].want);
      settle_block();

      // a run without crossings builds a long sample count before the result
      write_numerator('1);
      idle_pct = 0;
      for (int i = 0; i < FILL_ITEMS; i++) begin
         s = {$urandom(), $urandom()};
         s.ac_red = '0;
         send_sample(s, 1'b0, '0);
      end
      for (int i = 0; i < 4; i++) begin
         s = {$urandom(), $urandom()};
         s.ac_red = (i == 1) ? 16'hFFFF : (i == 3) ? 16'h0000 : 16'h0001;
         send_sample(s, 1'b0, '0);
      end
      settle_block();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       write_numerator(20'd1);
            1:       write_numerator('0);
            2:       write_numerator('1);
            5:       write_numerator(pom_pkg::NUM_RESET);
            default: write_numerator(pom_pkg::NUM_W'($urandom_range(1, 20'hFFFFF)));
         endcase
         case (ph)
            0:       idle_pct = 25;
            2:       idle_pct = 40;
            3:       idle_pct = 15;
            4:       idle_pct = 30;
            default: idle_pct = 0;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_sample(make_wave_sample(), 1'b0, '0);
         settle_block();
      end

      if (mismatch_count == 0)
         $display("pulse_oximeter_measure_tb: PASS");
      else
         $display("pulse_oximeter_measure_tb: FAIL");
      $finish;
   end

endmodule

// ===== pulse_oximeter_measure.f =====
hdl/pom_pkg.sv
hdl/pom_divider.sv
hdl/pom_ctrl.sv
hdl/pom_datapath.sv
hdl/pulse_oximeter_measure.sv
dv/pulse_oximeter_measure_tb.sv
